### sv/sparsity_row_sorted_insert_defines.svh
// Assertion macros for the sparsity row insert block.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef SPARSITY_ROW_SORTED_INSERT_DEFINES_SVH
`define SPARSITY_ROW_SORTED_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
`define SRSI_ASSERT_IMPL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SRSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRSI_ASSERT_IMPL(lbl, prop, msg)
`define SRSI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/srsi_pkg.sv
// Shared types and codes for the sparsity row insert block.
// No dependencies.
package srsi_pkg;

   typedef struct packed {
      logic       operation;
      logic [9:0] row;
      logic [9:0] column;
      logic [5:0] position;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] row_length;
      logic [9:0] read_value;
   } rsp_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [2:0] STAT_INSERTED  = 3'd0;
   localparam logic [2:0] STAT_PRESENT   = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_READ_OK   = 3'd3;
   localparam logic [2:0] STAT_READ_PAST = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LEN,
      S_PROBE,
      S_CMP,
      S_CHECK,
      S_SHIFT,
      S_PUT,
      S_RDATA,
      S_DONE
   } state_type;

endpackage

### sv/srsi_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module srsi_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/srsi_seq.sv
// Sequencer and shared compare/shift datapath for the sparsity row insert block.
// Depends on srsi_pkg; drives the entry and row-length RAMs.
module srsi_seq #(
   parameter int NUM_NODES = 1024,
   parameter int ROW_CAP   = 64,
   localparam int RW = $clog2(NUM_NODES),
   localparam int PW = $clog2(ROW_CAP),
   localparam int LW = $clog2(ROW_CAP + 1),
   localparam int AW = RW + PW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srsi_pkg::req_type req_data,
   output logic              res_valid,
   input  logic              res_ready,
   output srsi_pkg::rsp_type res_data,
   output logic              cnt_we,
   output logic [RW-1:0]     cnt_waddr,
   output logic [LW-1:0]     cnt_wdata,
   output logic [RW-1:0]     cnt_raddr,
   input  logic [LW-1:0]     cnt_rdata,
   output logic              ent_we,
   output logic [AW-1:0]     ent_waddr,
   output logic [9:0]        ent_wdata,
   output logic [AW-1:0]     ent_raddr,
   input  logic [9:0]        ent_rdata
);

   localparam int XW = (RW > 10) ? RW : 10;
   localparam int CW = (LW > 6) ? LW : 6;
   localparam int PX = (PW > 6) ? PW : 6;

   srsi_pkg::state_type state_ff, state_in;
   srsi_pkg::rsp_type   res_ff, res_in;
   logic                op_ff, op_in;
   logic                inr_ff, inr_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [9:0]          col_ff, col_in;
   logic [5:0]          pos_ff, pos_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [LW-1:0]       lo_ff, lo_in;
   logic [LW-1:0]       n_ff, n_in;
   logic [LW-1:0]       half_ff, half_in;
   logic [LW-1:0]       mid_ff, mid_in;
   logic [LW-1:0]       rem_ff, rem_in;
   logic [LW-1:0]       sh_ff, sh_in;
   logic                wpend_ff, wpend_in;
   logic [PW-1:0]       waddr_ff, waddr_in;
   logic [RW-1:0]       clr_ff, clr_in;

   logic [XW-1:0] row_x;
   logic [PX-1:0] pos_x;
   logic [LW-1:0] half_c, mid_c, shp1, len_p1;

   assign row_x  = XW'(req_data.row);
   assign pos_x  = PX'(pos_ff);
   assign half_c = n_ff >> 1;
   assign mid_c  = lo_ff + half_c;
   assign shp1   = sh_ff + LW'(1);
   assign len_p1 = len_ff + LW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srsi_pkg::S_CLEAR;
         clr_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wpend_ff <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      op_ff    <= op_in;
      inr_ff   <= inr_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      lo_ff    <= lo_in;
      n_ff     <= n_in;
      half_ff  <= half_in;
      mid_ff   <= mid_in;
      rem_ff   <= rem_in;
      sh_ff    <= sh_in;
      waddr_ff <= waddr_in;
   end

   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      op_in     = op_ff;
      inr_in    = inr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      lo_in     = lo_ff;
      n_in      = n_ff;
      half_in   = half_ff;
      mid_in    = mid_ff;
      rem_in    = rem_ff;
      sh_in     = sh_ff;
      wpend_in  = wpend_ff;
      waddr_in  = waddr_ff;
      clr_in    = clr_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = row_ff;
      cnt_wdata = '0;
      cnt_raddr = row_x[RW-1:0];
      ent_we    = 1'b0;
      ent_waddr = {row_ff, waddr_ff};
      ent_wdata = ent_rdata;
      ent_raddr = {row_ff, mid_c[PW-1:0]};

      unique case (state_ff)
         srsi_pkg::S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            clr_in    = clr_ff + RW'(1);
            if (clr_ff == RW'(NUM_NODES - 1)) begin
               state_in = srsi_pkg::S_IDLE;
            end
         end
         srsi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_data.operation;
               inr_in   = 32'(req_data.row) < NUM_NODES;
               row_in   = row_x[RW-1:0];
               col_in   = req_data.column;
               pos_in   = req_data.position;
               state_in = srsi_pkg::S_LEN;
            end
         end
         srsi_pkg::S_LEN: begin
            len_in            = cnt_rdata;
            res_in.read_value = '0;
            res_in.row_length = 7'(cnt_rdata);
            state_in          = srsi_pkg::S_DONE;
            if (!inr_ff) begin
               len_in            = '0;
               res_in.row_length = '0;
               res_in.status     = (op_ff == srsi_pkg::OP_READ) ?
                                   srsi_pkg::STAT_READ_PAST : srsi_pkg::STAT_FULL;
            end else if (op_ff == srsi_pkg::OP_READ) begin
               if (CW'(pos_ff) < CW'(cnt_rdata)) begin
                  ent_raddr = {row_ff, pos_x[PW-1:0]};
                  state_in  = srsi_pkg::S_RDATA;
               end else begin
                  res_in.status = srsi_pkg::STAT_READ_PAST;
               end
            end else if (cnt_rdata >= LW'(ROW_CAP)) begin
               res_in.status = srsi_pkg::STAT_FULL;
            end else begin
               lo_in    = '0;
               n_in     = cnt_rdata;
               state_in = srsi_pkg::S_PROBE;
            end
         end
         srsi_pkg::S_PROBE: begin
            rem_in   = len_ff - lo_ff;
            sh_in    = len_ff - LW'(1);
            wpend_in = 1'b0;
            if (n_ff != '0) begin
               half_in  = half_c;
               mid_in   = mid_c;
               state_in = srsi_pkg::S_CMP;
            end else if (lo_ff < len_ff) begin
               ent_raddr = {row_ff, lo_ff[PW-1:0]};
               state_in  = srsi_pkg::S_CHECK;
            end else begin
               state_in = srsi_pkg::S_SHIFT;
            end
         end
         srsi_pkg::S_CMP: begin
            if (ent_rdata < col_ff) begin
               lo_in = mid_ff + LW'(1);
               n_in  = n_ff - half_ff - LW'(1);
            end else begin
               n_in = half_ff;
            end
            state_in = srsi_pkg::S_PROBE;
         end
         srsi_pkg::S_CHECK: begin
            if (ent_rdata == col_ff) begin
               res_in.status     = srsi_pkg::STAT_PRESENT;
               res_in.row_length = 7'(len_ff);
               res_in.read_value = '0;
               state_in          = srsi_pkg::S_DONE;
            end else begin
               state_in = srsi_pkg::S_SHIFT;
            end
         end
         srsi_pkg::S_SHIFT: begin
            // read entry sh, write it one place up on the next cycle
            ent_raddr = {row_ff, sh_ff[PW-1:0]};
            if (rem_ff != '0) begin
               sh_in    = sh_ff - LW'(1);
               rem_in   = rem_ff - LW'(1);
               wpend_in = 1'b1;
               waddr_in = shp1[PW-1:0];
            end else begin
               wpend_in = 1'b0;
            end
            if (wpend_ff) begin
               ent_we = 1'b1;
            end
            if (rem_ff == '0 && !wpend_ff) begin
               state_in = srsi_pkg::S_PUT;
            end
         end
         srsi_pkg::S_PUT: begin
            ent_we            = 1'b1;
            ent_waddr         = {row_ff, lo_ff[PW-1:0]};
            ent_wdata         = col_ff;
            cnt_we            = 1'b1;
            cnt_wdata         = len_p1;
            res_in.status     = srsi_pkg::STAT_INSERTED;
            res_in.row_length = 7'(len_p1);
            res_in.read_value = '0;
            state_in          = srsi_pkg::S_DONE;
         end
         srsi_pkg::S_RDATA: begin
            res_in.status     = srsi_pkg::STAT_READ_OK;
            res_in.row_length = 7'(len_ff);
            res_in.read_value = ent_rdata;
            state_in          = srsi_pkg::S_DONE;
         end
         srsi_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = srsi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srsi_pkg::S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

endmodule

### sv/sparsity_row_sorted_insert.sv
// Sparsity pattern builder: per-row sorted, duplicate-free column lists.
// Depends on srsi_pkg, srsi_ram, srsi_seq and sparsity_row_sorted_insert_defines.svh.
//
// Usage:
//   req_* carries one operation (insert column into row, or read entry at a
//   position of a row); rsp_* returns exactly one result per transfer with
//   status, row length after the operation and the read value.
//   Items are handled one at a time; req_ready is low while an item is worked.
//   Insert: reads the row length, binary-searches the row (up to
//   ceil(log2(ROW_CAP)) probes), checks the entry found for a duplicate,
//   shifts the entries from there up by one through the entry RAM (no check
//   and no moves when the column goes last), writes the column and the new
//   length and hands the result over. Read: reads the row length, then the
//   entry at the position. Full row or row out of range: answered from the
//   row length alone. After reset the row-length RAM is cleared, one row per
//   cycle, before req_ready first rises. The result sits in an output
//   register; a new request is taken while it waits, and a stalled rsp_ready
//   holds the payload steady. A finished item then waits until the output
//   register is free.
`include "sparsity_row_sorted_insert_defines.svh"

module sparsity_row_sorted_insert #(
   parameter int NUM_NODES = 1024,
   parameter int ROW_CAP   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srsi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srsi_pkg::rsp_type rsp_data
);

   localparam int RW = $clog2(NUM_NODES);
   localparam int PW = $clog2(ROW_CAP);
   localparam int LW = $clog2(ROW_CAP + 1);
   localparam int AW = RW + PW;

   logic              res_valid, res_ready;
   srsi_pkg::rsp_type res_data;
   logic              cnt_we;
   logic [RW-1:0]     cnt_waddr, cnt_raddr;
   logic [LW-1:0]     cnt_wdata, cnt_rdata;
   logic              ent_we;
   logic [AW-1:0]     ent_waddr, ent_raddr;
   logic [9:0]        ent_wdata, ent_rdata;

   logic              rsp_valid_ff;
   srsi_pkg::rsp_type rsp_data_ff;

   srsi_seq #(
      .NUM_NODES (NUM_NODES),
      .ROW_CAP   (ROW_CAP)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .cnt_we    (cnt_we),
      .cnt_waddr (cnt_waddr),
      .cnt_wdata (cnt_wdata),
      .cnt_raddr (cnt_raddr),
      .cnt_rdata (cnt_rdata),
      .ent_we    (ent_we),
      .ent_waddr (ent_waddr),
      .ent_wdata (ent_wdata),
      .ent_raddr (ent_raddr),
      .ent_rdata (ent_rdata)
   );

   srsi_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_NODES)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   srsi_ram #(
      .WIDTH (10),
      .DEPTH (NUM_NODES * (2 ** PW))
   ) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SRSI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `SRSI_ASSERT_IMPL(a_status_code, !rsp_valid || rsp_data.status == srsi_pkg::STAT_INSERTED || rsp_data.status == srsi_pkg::STAT_PRESENT || rsp_data.status == srsi_pkg::STAT_FULL || rsp_data.status == srsi_pkg::STAT_READ_OK || rsp_data.status == srsi_pkg::STAT_READ_PAST, "bad status code")
   `SRSI_ASSERT_IMPL(a_value_zero, !rsp_valid || rsp_data.status == srsi_pkg::STAT_READ_OK || rsp_data.read_value == 10'd0, "read value not zero")

endmodule
